FILE: rtl/dtg_pkg.sv
// dtg_pkg: shared widths, status and operation codes, tone frequencies and
// the digit decoder of the dtmf tone generator.
// No dependencies; every other file of the block uses it by scoped names.
package dtg_pkg;

   // field and state widths
   localparam int RATE_W   = 18;
   localparam int PHASE_W  = 32;
   localparam int FREQ_W   = 11;
   localparam int IDX_W    = 17;
   localparam int SAMPLE_W = 16;
   localparam int STATUS_W = 3;
   localparam int CODE_W   = 8;

   // sample rate after reset, in hertz
   localparam logic [RATE_W-1:0] RATE_RESET = 18'd8000;

   // operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_SAMPLE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BUSY      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_IDLE_TICK = 3'd4;

   // row and column tone frequencies in hertz
   localparam logic [FREQ_W-1:0] FREQ_ROW1 = 11'd697;
   localparam logic [FREQ_W-1:0] FREQ_ROW2 = 11'd770;
   localparam logic [FREQ_W-1:0] FREQ_ROW3 = 11'd852;
   localparam logic [FREQ_W-1:0] FREQ_ROW4 = 11'd941;
   localparam logic [FREQ_W-1:0] FREQ_COL1 = 11'd1209;
   localparam logic [FREQ_W-1:0] FREQ_COL2 = 11'd1336;
   localparam logic [FREQ_W-1:0] FREQ_COL3 = 11'd1477;
   localparam logic [FREQ_W-1:0] FREQ_COL4 = 11'd1633;

   // output gain, 0.45 * 65536 (about 0.9 of full scale for the sum)
   localparam logic signed [SAMPLE_W-1:0] AMPLITUDE_Q16 = 16'sd29491;

   // distance between lower and upper case latin letters
   localparam logic [CODE_W-1:0] CASE_OFFSET = 8'd32;

   typedef struct packed {
      logic [FREQ_W-1:0] row;
      logic [FREQ_W-1:0] col;
   } tone_pair_type;

   // request to the step divider
   typedef struct packed {
      logic              start;
      logic [FREQ_W-1:0] freq;
      logic [RATE_W-1:0] divisor;
   } div_req_type;

   // answer of the step divider
   typedef struct packed {
      logic               done;
      logic [PHASE_W-1:0] quotient;
   } div_rsp_type;

   // rate update towards the length unit
   typedef struct packed {
      logic              write;
      logic [RATE_W-1:0] rate;
   } len_req_type;

   // part lengths in samples, busy while being recomputed
   typedef struct packed {
      logic             busy;
      logic [IDX_W-1:0] tone_len;
      logic [IDX_W-1:0] gap_len;
   } len_status_type;

   // keypad lookup, row of zero marks an unknown character
   function automatic tone_pair_type decode_digit(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] ch;
      tone_pair_type     pair;
      ch = code;
      if (code >= "a" && code <= "d") begin
         ch = code - CASE_OFFSET;
      end
      case (ch)
         "1": begin pair.row = FREQ_ROW1; pair.col = FREQ_COL1; end
         "2": begin pair.row = FREQ_ROW1; pair.col = FREQ_COL2; end
         "3": begin pair.row = FREQ_ROW1; pair.col = FREQ_COL3; end
         "A": begin pair.row = FREQ_ROW1; pair.col = FREQ_COL4; end
         "4": begin pair.row = FREQ_ROW2; pair.col = FREQ_COL1; end
         "5": begin pair.row = FREQ_ROW2; pair.col = FREQ_COL2; end
         "6": begin pair.row = FREQ_ROW2; pair.col = FREQ_COL3; end
         "B": begin pair.row = FREQ_ROW2; pair.col = FREQ_COL4; end
         "7": begin pair.row = FREQ_ROW3; pair.col = FREQ_COL1; end
         "8": begin pair.row = FREQ_ROW3; pair.col = FREQ_COL2; end
         "9": begin pair.row = FREQ_ROW3; pair.col = FREQ_COL3; end
         "C": begin pair.row = FREQ_ROW3; pair.col = FREQ_COL4; end
         "*": begin pair.row = FREQ_ROW4; pair.col = FREQ_COL1; end
         "0": begin pair.row = FREQ_ROW4; pair.col = FREQ_COL2; end
         "#": begin pair.row = FREQ_ROW4; pair.col = FREQ_COL3; end
         "D": begin pair.row = FREQ_ROW4; pair.col = FREQ_COL4; end
         default: begin
            pair.row = '0;
            pair.col = '0;
         end
      endcase
      return pair;
   endfunction

endpackage

FILE: rtl/dtg_req_if.sv
// dtg_req_if: command channel of the dtmf tone generator (digit starts, ticks).
// Depends on dtg_pkg for field widths.
interface dtg_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [dtg_pkg::CODE_W-1:0] digit_code;

   modport source (output valid, operation, digit_code, input ready);
   modport sink   (input valid, operation, digit_code, output ready);
endinterface

FILE: rtl/dtg_rsp_if.sv
// dtg_rsp_if: result channel of the dtmf tone generator.
// Depends on dtg_pkg for field widths.
interface dtg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dtg_pkg::SAMPLE_W-1:0] sample;
   logic [dtg_pkg::STATUS_W-1:0]        status;
   logic                                in_tone;
   logic                                last_of_digit;

   modport source (output valid, sample, status, in_tone, last_of_digit, input ready);
   modport sink   (input valid, sample, status, in_tone, last_of_digit, output ready);
endinterface

FILE: rtl/dtg_csr_if.sv
// dtg_csr_if: write channel of the sample rate register.
// Depends on dtg_pkg for the register width.
interface dtg_csr_if;
   logic                       valid;
   logic                       ready;
   logic [dtg_pkg::RATE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/dtg_divider.sv
// dtg_divider: bit-serial restoring divider for the phase steps,
// quotient = floor(freq * 2^32 / divisor) mod 2^32. Depends on dtg_pkg.
module dtg_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  dtg_pkg::div_req_type div_req,
   output dtg_pkg::div_rsp_type div_rsp
);

   localparam int DVD_W = dtg_pkg::FREQ_W + dtg_pkg::PHASE_W;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic                          run_ff;
   logic                          done_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [DVD_W-1:0]              dvd_ff;
   logic [dtg_pkg::RATE_W-1:0]    rem_ff;
   logic [dtg_pkg::RATE_W-1:0]    div_ff;
   logic [dtg_pkg::PHASE_W-1:0]   quo_ff;
   logic [dtg_pkg::RATE_W:0]      rem_shift;
   logic                          take;
   logic [dtg_pkg::RATE_W-1:0]    rem_in;

   // one quotient bit per cycle
   assign rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign take      = rem_shift >= {1'b0, div_ff};
   assign rem_in    = take ? dtg_pkg::RATE_W'(rem_shift - {1'b0, div_ff})
                           : rem_shift[dtg_pkg::RATE_W-1:0];

   // iteration control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            dvd_ff   <= {div_req.freq, dtg_pkg::PHASE_W'(0)};
            rem_ff   <= '0;
            div_ff   <= div_req.divisor;
            count_ff <= CNT_W'(DVD_W);
            run_ff   <= 1'b1;
         end else if (run_ff) begin
            dvd_ff   <= {dvd_ff[DVD_W-2:0], 1'b0};
            rem_ff   <= rem_in;
            quo_ff   <= {quo_ff[dtg_pkg::PHASE_W-2:0], take};
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: rtl/dtg_length.sv
// dtg_length: tone and gap part lengths, rate * ms / 1000, recomputed in a
// short pipeline after each rate write. Depends on dtg_pkg.
module dtg_length #(
   parameter int TONE_MS = 200,
   parameter int GAP_MS  = 200
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dtg_pkg::len_req_type    len_req,
   output dtg_pkg::len_status_type len_status
);

   localparam int MAX_MS      = (TONE_MS > GAP_MS) ? TONE_MS : GAP_MS;
   localparam int MS_W        = $clog2(MAX_MS + 1);
   localparam int PROD_W      = dtg_pkg::RATE_W + MS_W;
   // 1000 = 8 * 125: shift by three, then divide by 125 through a reciprocal
   localparam int EIGHT_SHIFT = 3;
   localparam int DIV_REST    = 125;
   localparam int X_W         = PROD_W - EIGHT_SHIFT;
   localparam int RECIP_SHIFT = 31;
   localparam int RECIP_W     = 25;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_REST);
   localparam int LANES       = 2;
   localparam logic [MS_W-1:0] LANE_MS [LANES] = '{MS_W'(TONE_MS), MS_W'(GAP_MS)};
   localparam logic [dtg_pkg::IDX_W-1:0] TONE_RESET =
      dtg_pkg::IDX_W'(int'(dtg_pkg::RATE_RESET) * TONE_MS / 1000);
   localparam logic [dtg_pkg::IDX_W-1:0] GAP_RESET =
      dtg_pkg::IDX_W'(int'(dtg_pkg::RATE_RESET) * GAP_MS / 1000);

   logic                          stage1_ff;
   logic                          stage2_ff;
   logic [PROD_W-1:0]             prod_ff [LANES];
   logic [X_W-1:0]                x_ff    [LANES];
   logic [X_W-1:0]                est_ff  [LANES];
   logic [X_W+RECIP_W-1:0]        recip_prod [LANES];
   logic [X_W-1:0]                rem       [LANES];
   logic [dtg_pkg::IDX_W-1:0]     len_in    [LANES];
   logic [dtg_pkg::IDX_W-1:0]     len_ff    [LANES];

   // reciprocal estimate, low by at most one, then one compare and correct
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         recip_prod[l] = (X_W + RECIP_W)'(prod_ff[l][PROD_W-1:EIGHT_SHIFT]) *
                         (X_W + RECIP_W)'(RECIP);
         rem[l]        = x_ff[l] - X_W'(est_ff[l] * X_W'(DIV_REST));
         len_in[l]     = (rem[l] >= X_W'(DIV_REST))
                         ? dtg_pkg::IDX_W'(est_ff[l] + 1'b1)
                         : dtg_pkg::IDX_W'(est_ff[l]);
      end
   end

   // three register stages per lane
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         len_ff[0] <= TONE_RESET;
         len_ff[1] <= GAP_RESET;
      end else begin
         stage1_ff <= len_req.write;
         stage2_ff <= stage1_ff;
         for (int l = 0; l < LANES; l++) begin
            prod_ff[l] <= PROD_W'(len_req.rate) * PROD_W'(LANE_MS[l]);
            x_ff[l]    <= prod_ff[l][PROD_W-1:EIGHT_SHIFT];
            est_ff[l]  <= X_W'(recip_prod[l] >> RECIP_SHIFT);
            if (stage2_ff) begin
               len_ff[l] <= len_in[l];
            end
         end
      end
   end

   assign len_status.busy     = stage1_ff || stage2_ff;
   assign len_status.tone_len = len_ff[0];
   assign len_status.gap_len  = len_ff[1];

endmodule

FILE: rtl/dtg_sine_rom.sv
// dtg_sine_rom: Q1.15 sine table with a registered read port, filled at
// elaboration from a fixed-point Taylor series. Depends on dtg_pkg.
module dtg_sine_rom #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic [SINE_TABLE_BITS-1:0]          rd_addr,
   output logic signed [dtg_pkg::SAMPLE_W-1:0] rd_data
);

   localparam int ROM_SIZE     = 1 << SINE_TABLE_BITS;
   localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
   localparam int QUARTER      = 1 << QUARTER_BITS;
   localparam int Q30          = 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] HALF_LSB    = 64'd1 << (Q30 - 1);
   localparam logic [63:0] FULL_SCALE  = 64'd32767;

   typedef logic signed [dtg_pkg::SAMPLE_W-1:0] rom_type [ROM_SIZE];

   // next power of the angle, two factors of x in Q30
   function automatic logic [63:0] power_step(input logic [63:0] term,
                                              input logic [63:0] x);
      logic [63:0] t;
      t = (term * x) >> Q30;
      return (t * x) >> Q30;
   endfunction

   // first quadrant value for position r of a quarter wave
   function automatic logic [dtg_pkg::SAMPLE_W-1:0] quarter_sine(input int unsigned r);
      logic [63:0] x;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] v;
      x    = (HALF_PI_Q30 * 64'(r)) >> QUARTER_BITS;
      sum  = x;
      term = x;
      term = power_step(term, x) / 64'd6;   sum = sum - term;
      term = power_step(term, x) / 64'd20;  sum = sum + term;
      term = power_step(term, x) / 64'd42;  sum = sum - term;
      term = power_step(term, x) / 64'd72;  sum = sum + term;
      term = power_step(term, x) / 64'd110; sum = sum - term;
      term = power_step(term, x) / 64'd156; sum = sum + term;
      term = power_step(term, x) / 64'd210; sum = sum - term;
      term = power_step(term, x) / 64'd272; sum = sum + term;
      v = (sum * FULL_SCALE + HALF_LSB) >> Q30;
      return (v > FULL_SCALE) ? dtg_pkg::SAMPLE_W'(FULL_SCALE) : v[dtg_pkg::SAMPLE_W-1:0];
   endfunction

   // full wave from quarter-wave symmetry
   function automatic rom_type build_rom();
      rom_type                        rom;
      int unsigned                    quad;
      int unsigned                    r;
      logic [dtg_pkg::SAMPLE_W-1:0]   m;
      for (int k = 0; k < ROM_SIZE; k++) begin
         quad = k >> QUARTER_BITS;
         r    = k & (QUARTER - 1);
         m    = ((quad & 1) != 0) ? quarter_sine(QUARTER - r) : quarter_sine(r);
         rom[k] = ((quad & 2) != 0) ? -$signed(m) : $signed(m);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic signed [dtg_pkg::SAMPLE_W-1:0] rd_data_ff;

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= SINE_ROM[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dtmf_tone_generator.sv
// dtmf_tone_generator: keypad digit commands in, 16-bit pcm samples out.
// Depends on dtg_pkg, the three channel interfaces, dtg_divider,
// dtg_length and dtg_sine_rom.
//
//   channel  | dir | fields                                     | role
//   ---------+-----+--------------------------------------------+--------------------
//   req_chan | in  | operation, digit_code                      | digit start / tick
//   rsp_chan | out | sample, status, in_tone, last_of_digit     | one result per item
//   csr_chan | in  | data (sample_rate)                         | rate register write
//
// An accepted digit start makes two 43-step passes of the shared bit-serial
// step divider. A rejected start or a tick outside the tone goes straight to
// the respond state; a tone tick passes through the phase memory read, the sine
// rom read for each tone and the gain multiplier. A rate write holds the command
// channel while the part lengths are redone. Reset is synchronous, no clearing
// pass; a stalled result waits in the output register.
module dtmf_tone_generator #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int TONE_MS         = 200,
   parameter int GAP_MS          = 200
) (
   input  logic       clock,
   input  logic       reset,
   dtg_req_if.sink    req_chan,
   dtg_rsp_if.source  rsp_chan,
   dtg_csr_if.sink    csr_chan
);

   localparam logic SEL_ROW = 1'b0;
   localparam logic SEL_COL = 1'b1;
   localparam int   PW      = dtg_pkg::PHASE_W;
   localparam int   SW      = dtg_pkg::SAMPLE_W;
   localparam int   MULT_W  = 2 * SW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_ROW,
      ST_DIV_COL,
      ST_TONE_ROW,
      ST_TONE_COL,
      ST_TONE_MUL,
      ST_TONE_OUT,
      ST_RESPOND
   } state_type;

   state_type                        state_ff;
   logic [dtg_pkg::RATE_W-1:0]       rate_ff;
   logic                             busy_ff;
   logic                             in_gap_ff;
   logic [dtg_pkg::IDX_W-1:0]        idx_ff;
   logic [dtg_pkg::FREQ_W-1:0]       col_freq_ff;
   logic signed [SW-1:0]             s_row_ff;
   logic signed [MULT_W-1:0]         mult_ff;
   logic signed [SW-1:0]             res_sample_ff;
   logic [dtg_pkg::STATUS_W-1:0]     res_status_ff;
   logic                             res_tone_ff;
   logic                             res_last_ff;
   logic                             rsp_valid_ff;
   logic signed [SW-1:0]             out_sample_ff;
   logic [dtg_pkg::STATUS_W-1:0]     out_status_ff;
   logic                             out_tone_ff;
   logic                             out_last_ff;

   // phase and step memories, one entry per tone
   logic [PW-1:0]                    phase_mem [2];
   logic [PW-1:0]                    step_mem  [2];
   logic [PW-1:0]                    phase_rd_ff;
   logic [PW-1:0]                    step_rd_ff;
   logic                             rd_sel;
   logic                             wr_sel;
   logic                             phase_we;
   logic                             step_we;
   logic [PW-1:0]                    phase_wr_data;

   logic                             req_accept;
   logic                             rsp_take;
   logic                             out_free;
   logic                             start_ok;
   dtg_pkg::tone_pair_type           tone_pair;
   dtg_pkg::div_req_type             div_req;
   dtg_pkg::div_rsp_type             div_rsp;
   dtg_pkg::len_req_type             len_req;
   dtg_pkg::len_status_type          len_status;
   logic signed [SW-1:0]             rom_data;
   logic signed [SW:0]               tone_sum;
   logic signed [MULT_W-1:0]         mult_in;

   logic [dtg_pkg::IDX_W-1:0]        idx_inc;
   logic [dtg_pkg::IDX_W-1:0]        adv_idx;
   logic                             adv_busy;
   logic                             adv_gap;
   logic                             adv_last;

   // handshakes
   assign req_chan.ready = (state_ff == ST_IDLE) && !len_status.busy;
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // digit decode and start check
   assign tone_pair = dtg_pkg::decode_digit(req_chan.digit_code);
   assign start_ok  = (tone_pair.row != '0) && (rate_ff != '0);

   // position update for one tick of the current digit
   always_comb begin
      idx_inc  = dtg_pkg::IDX_W'(idx_ff + 1'b1);
      adv_idx  = idx_inc;
      adv_busy = busy_ff;
      adv_gap  = in_gap_ff;
      adv_last = 1'b0;
      if (!in_gap_ff) begin
         if (idx_inc >= len_status.tone_len) begin
            adv_idx = '0;
            if (len_status.gap_len != '0) begin
               adv_gap = 1'b1;
            end else begin
               adv_busy = 1'b0;
               adv_last = 1'b1;
            end
         end
      end else if (idx_inc >= len_status.gap_len) begin
         adv_idx  = '0;
         adv_busy = 1'b0;
         adv_gap  = 1'b0;
         adv_last = 1'b1;
      end
   end

   // memory port control; in the tone states an entry is never read in the cycle it is written
   always_comb begin
      rd_sel        = (state_ff == ST_TONE_ROW) ? SEL_COL : SEL_ROW;
      wr_sel        = SEL_ROW;
      phase_we      = 1'b0;
      step_we       = 1'b0;
      phase_wr_data = PW'(phase_rd_ff + step_rd_ff);
      case (state_ff)
         ST_DIV_ROW: begin
            phase_we      = div_rsp.done;
            step_we       = div_rsp.done;
            phase_wr_data = '0;
         end
         ST_DIV_COL: begin
            wr_sel        = SEL_COL;
            phase_we      = div_rsp.done;
            step_we       = div_rsp.done;
            phase_wr_data = '0;
         end
         ST_TONE_ROW: begin
            phase_we = 1'b1;
         end
         ST_TONE_COL: begin
            wr_sel   = SEL_COL;
            phase_we = 1'b1;
         end
         default: begin
            phase_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (phase_we) begin
         phase_mem[wr_sel] <= phase_wr_data;
      end
      phase_rd_ff <= phase_mem[rd_sel];
   end

   always_ff @(posedge clock) begin
      if (step_we) begin
         step_mem[wr_sel] <= div_rsp.quotient;
      end
      step_rd_ff <= step_mem[rd_sel];
   end

   // shared step divider: row tone first, column tone on its completion
   assign div_req.start   = (req_accept && req_chan.operation == dtg_pkg::OP_START &&
                             !busy_ff && start_ok) ||
                            (state_ff == ST_DIV_ROW && div_rsp.done);
   assign div_req.freq    = (state_ff == ST_IDLE) ? tone_pair.row : col_freq_ff;
   assign div_req.divisor = rate_ff;

   dtg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // part lengths follow each rate write
   assign len_req.write = csr_chan.valid && csr_chan.ready;
   assign len_req.rate  = csr_chan.data;

   dtg_length #(
      .TONE_MS (TONE_MS),
      .GAP_MS  (GAP_MS)
   ) u_length (
      .clock      (clock),
      .reset      (reset),
      .len_req    (len_req),
      .len_status (len_status)
   );

   // sine lookup at the phase just read
   dtg_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock   (clock),
      .rd_addr (phase_rd_ff[PW-1 -: SINE_TABLE_BITS]),
      .rd_data (rom_data)
   );

   // tone sum times gain; the sum bound keeps the top half within 16 bits
   assign tone_sum = {s_row_ff[SW-1], s_row_ff} + {rom_data[SW-1], rom_data};
   assign mult_in  = MULT_W'(tone_sum) * MULT_W'(dtg_pkg::AMPLITUDE_Q16);

   // sequencer, digit state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= dtg_pkg::RATE_RESET;
         busy_ff      <= 1'b0;
         in_gap_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            rate_ff <= csr_chan.data;
         end
         if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  res_sample_ff <= '0;
                  res_tone_ff   <= 1'b0;
                  res_last_ff   <= 1'b0;
                  if (req_chan.operation == dtg_pkg::OP_START) begin
                     if (busy_ff) begin
                        res_status_ff <= dtg_pkg::STATUS_BUSY;
                        state_ff      <= ST_RESPOND;
                     end else if (!start_ok) begin
                        res_status_ff <= dtg_pkg::STATUS_UNKNOWN;
                        state_ff      <= ST_RESPOND;
                     end else begin
                        col_freq_ff <= tone_pair.col;
                        state_ff    <= ST_DIV_ROW;
                     end
                  end else if (!busy_ff) begin
                     res_status_ff <= dtg_pkg::STATUS_IDLE_TICK;
                     state_ff      <= ST_RESPOND;
                  end else if (in_gap_ff) begin
                     // silent gap sample
                     res_status_ff <= dtg_pkg::STATUS_SAMPLE;
                     res_last_ff   <= adv_last;
                     idx_ff        <= adv_idx;
                     busy_ff       <= adv_busy;
                     in_gap_ff     <= adv_gap;
                     state_ff      <= ST_RESPOND;
                  end else begin
                     state_ff <= ST_TONE_ROW;
                  end
               end
            end
            ST_DIV_ROW: begin
               if (div_rsp.done) begin
                  state_ff <= ST_DIV_COL;
               end
            end
            ST_DIV_COL: begin
               if (div_rsp.done) begin
                  idx_ff        <= '0;
                  res_status_ff <= dtg_pkg::STATUS_ACCEPTED;
                  if (len_status.tone_len != '0) begin
                     busy_ff   <= 1'b1;
                     in_gap_ff <= 1'b0;
                  end else if (len_status.gap_len != '0) begin
                     busy_ff   <= 1'b1;
                     in_gap_ff <= 1'b1;
                  end
                  state_ff <= ST_RESPOND;
               end
            end
            ST_TONE_ROW: begin
               state_ff <= ST_TONE_COL;
            end
            ST_TONE_COL: begin
               s_row_ff <= rom_data;
               state_ff <= ST_TONE_MUL;
            end
            ST_TONE_MUL: begin
               mult_ff  <= mult_in;
               state_ff <= ST_TONE_OUT;
            end
            ST_TONE_OUT: begin
               res_sample_ff <= mult_ff[MULT_W-1 -: SW];
               res_status_ff <= dtg_pkg::STATUS_SAMPLE;
               res_tone_ff   <= 1'b1;
               res_last_ff   <= adv_last;
               idx_ff        <= adv_idx;
               busy_ff       <= adv_busy;
               in_gap_ff     <= adv_gap;
               state_ff      <= ST_RESPOND;
            end
            ST_RESPOND: begin
               if (out_free) begin
                  out_sample_ff <= res_sample_ff;
                  out_status_ff <= res_status_ff;
                  out_tone_ff   <= res_tone_ff;
                  out_last_ff   <= res_last_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample        = out_sample_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.in_tone       = out_tone_ff;
   assign rsp_chan.last_of_digit = out_last_ff;

endmodule

FILE: rtl/dtg_checker.sv
// dtg_checker: port-level checks of the dtmf tone generator, bound to the
// top level. Depends on dtg_pkg and dtmf_tone_generator.
module dtg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [dtg_pkg::SAMPLE_W-1:0] rsp_sample,
   input logic [dtg_pkg::STATUS_W-1:0]        rsp_status,
   input logic                                rsp_in_tone,
   input logic                                rsp_last
);

   // one command at a time: a transfer closes the command channel
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("command channel still open after a transfer");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample) &&
         $stable(rsp_status) && $stable(rsp_in_tone) && $stable(rsp_last)))
      else $error("stalled result changed");

   // only sample results carry audio or digit flags
   a_non_sample_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != dtg_pkg::STATUS_SAMPLE) |->
         (rsp_sample == '0 && !rsp_in_tone && !rsp_last))
      else $error("non-sample result with sample data or flags");

   // no result offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind dtmf_tone_generator dtg_checker u_dtg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_sample  (rsp_chan.sample),
   .rsp_status  (rsp_chan.status),
   .rsp_in_tone (rsp_chan.in_tone),
   .rsp_last    (rsp_chan.last_of_digit)
);
